// ----- sv/tdpt_pkg.sv -----
// Package for the trial-division prime test unit.
// Holds the widths, the seed constants and the controller/datapath command and status structs.
// Depends on nothing.
`default_nettype none

package tdpt_pkg;

    // Width of the numbers that are tested.
    localparam int WIDTH = 32;
    // The running square is two bits wider than the value, so it cannot wrap.
    localparam int SQ_W = WIDTH + 2;
    // Counter width for one bit of the modulo per cycle.
    localparam int CNT_W = $clog2(WIDTH);
    // Width of the payload bus.
    localparam int DATA_W = 32;
    localparam int USER_IN_W = 1;
    localparam int USER_OUT_W = 2;

    // Action codes.
    localparam logic ACT_TEST = 1'b0;
    localparam logic ACT_NEXT = 1'b1;

    // Seeds of the divisor loop.
    localparam logic [WIDTH-1:0] P_INIT = WIDTH'(3);
    localparam logic [SQ_W-1:0] SQ_INIT = SQ_W'(9);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the incoming request
        logic inc_cand;   // candidate = candidate + 1
        logic init_p;     // divisor = 3, square = 9
        logic step_p;     // divisor += 2, square += 4 * (new divisor - 1)
        logic mod_start;  // start candidate % divisor
        logic res_load;   // load the output register
        logic res_prime;  // verdict to load
        logic res_ovf;    // overflow flag to load
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic action_next;
        logic cand_lt2;
        logic cand_small_prime;
        logic cand_even;
        logic cand_max;
        logic sq_lt_cand;
        logic mod_done;
        logic rem_zero;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/tdpt_mod_unit.sv -----
// Bit-serial restoring modulo unit: one dividend bit per cycle.
// Depends on tdpt_pkg.
`default_nettype none

module tdpt_mod_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [tdpt_pkg::WIDTH-1:0] dividend,
    input  wire logic [tdpt_pkg::WIDTH-1:0] divisor,
    output logic                           done,
    output logic                           rem_zero
);
    import tdpt_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WIDTH-1:0]  dvd_reg, dvd_next;
    logic [WIDTH-1:0]  dvs_reg, dvs_next;
    logic [WIDTH-1:0]  rem_reg, rem_next;
    logic [WIDTH:0]    trial;
    logic [WIDTH:0]    diff;

    assign trial = {rem_reg, dvd_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // Partial remainder stays below the divisor, so WIDTH bits hold it.
            if (trial >= {1'b0, dvs_reg})
                rem_next = diff[WIDTH-1:0];
            else
                rem_next = trial[WIDTH-1:0];
            dvd_next = {dvd_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == '0);

endmodule

`default_nettype wire

// ----- sv/tdpt_datapath.sv -----
// Datapath: request capture, candidate, divisor and running square, modulo unit, result register.
// Depends on tdpt_pkg and tdpt_mod_unit.
`default_nettype none

module tdpt_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tdpt_pkg::dp_cmd_t             cmd,
    output tdpt_pkg::dp_status_t               status,
    input  wire logic [tdpt_pkg::DATA_W-1:0]     in_data,
    input  wire logic [tdpt_pkg::USER_IN_W-1:0]  in_user,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [tdpt_pkg::DATA_W-1:0]          out_data,
    output logic [tdpt_pkg::USER_OUT_W-1:0]      out_user
);
    import tdpt_pkg::*;

    logic              action_reg, action_next;
    logic [WIDTH-1:0]  cand_reg, cand_next;
    logic [WIDTH-1:0]  p_reg, p_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic              ovalid_reg, ovalid_next;
    logic [DATA_W-1:0] odata_reg, odata_next;
    logic [USER_OUT_W-1:0] ouser_reg, ouser_next;
    logic [WIDTH-1:0]  p_plus1;
    logic              mod_done;
    logic              rem_zero;

    assign p_plus1 = p_reg + WIDTH'(1);

    always_comb
    begin
        action_next = action_reg;
        cand_next   = cand_reg;
        p_next      = p_reg;
        sq_next     = sq_reg;
        if (cmd.load)
        begin
            action_next = in_user[0];
            cand_next   = in_data[WIDTH-1:0];
        end
        else if (cmd.inc_cand)
            cand_next = cand_reg + WIDTH'(1);
        if (cmd.init_p)
        begin
            p_next  = P_INIT;
            sq_next = SQ_INIT;
        end
        else if (cmd.step_p)
        begin
            // New divisor is p + 2, so the square grows by 4 * (p + 1).
            p_next  = p_reg + WIDTH'(2);
            sq_next = sq_reg + {p_plus1, 2'b00};
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        ouser_next  = ouser_reg;
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
        if (cmd.res_load)
        begin
            ovalid_next = 1'b1;
            odata_next  = cmd.res_ovf ? '0 : DATA_W'(cand_reg);
            ouser_next  = {cmd.res_ovf, cmd.res_prime};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else
            ovalid_reg <= ovalid_next;
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        cand_reg   <= cand_next;
        p_reg      <= p_next;
        sq_reg     <= sq_next;
        odata_reg  <= odata_next;
        ouser_reg  <= ouser_next;
    end

    tdpt_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (cand_reg),
        .divisor  (p_reg),
        .done     (mod_done),
        .rem_zero (rem_zero)
    );

    always_comb
    begin
        status.action_next      = (action_reg == ACT_NEXT);
        status.cand_lt2         = (cand_reg < WIDTH'(2));
        status.cand_small_prime = (cand_reg == WIDTH'(2)) || (cand_reg == WIDTH'(3));
        status.cand_even        = ~cand_reg[0];
        status.cand_max         = &cand_reg;
        status.sq_lt_cand       = (sq_reg < {2'b00, cand_reg});
        status.mod_done         = mod_done;
        status.rem_zero         = rem_zero;
        status.out_busy         = ovalid_reg && !out_ready;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_user  = ouser_reg;

endmodule

`default_nettype wire

// ----- sv/tdpt_controller.sv -----
// Controller state machine that sequences candidates and trial divisors.
// Depends on tdpt_pkg.
`default_nettype none

module tdpt_controller (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire tdpt_pkg::dp_status_t  status,
    output tdpt_pkg::dp_cmd_t          cmd
);
    import tdpt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CLASSIFY,
        S_MOD_START,
        S_MOD_WAIT,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   prime_reg, prime_next;
    logic   ovf_reg, ovf_next;

    always_comb
    begin
        state_next = state_reg;
        prime_next = prime_reg;
        ovf_next   = ovf_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                // A search starts at the successor of the current candidate.
                if (!status.action_next)
                    state_next = S_CLASSIFY;
                else if (status.cand_max)
                begin
                    prime_next = 1'b0;
                    ovf_next   = 1'b1;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.inc_cand = 1'b1;
                    state_next   = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                ovf_next = 1'b0;
                if (status.cand_lt2 || (status.cand_even && !status.cand_small_prime))
                begin
                    prime_next = 1'b0;
                    state_next = status.action_next ? S_PREP : S_RESULT;
                end
                else if (status.cand_small_prime)
                begin
                    prime_next = 1'b1;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.init_p = 1'b1;
                    state_next = S_MOD_START;
                end
            end
            S_MOD_START:
            begin
                cmd.mod_start = 1'b1;
                state_next    = S_MOD_WAIT;
            end
            S_MOD_WAIT:
            begin
                if (status.mod_done)
                begin
                    if (status.rem_zero)
                    begin
                        prime_next = 1'b0;
                        state_next = status.action_next ? S_PREP : S_RESULT;
                    end
                    else if (!status.sq_lt_cand)
                    begin
                        prime_next = 1'b1;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        cmd.step_p = 1'b1;
                        state_next = S_MOD_START;
                    end
                end
            end
            S_RESULT:
            begin
                if (!status.out_busy)
                begin
                    cmd.res_load  = 1'b1;
                    cmd.res_prime = prime_reg;
                    cmd.res_ovf   = ovf_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            prime_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            prime_reg <= prime_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/trial_division_prime_test_unit.sv -----
// Top level of the trial-division prime test unit.
// Depends on tdpt_pkg, tdpt_controller and tdpt_datapath.
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tuser: action; s_tdata: value
// m_*       out  m_tvalid/m_tready    m_tuser: is_prime, overflow; m_tdata: prime_value
//
// One request is worked at a time. A test decided without a divisor (below 2, 2, 3 or
// even) passes from acceptance through the prepare, classify and result states. Each
// odd trial divisor costs a start, a serial modulo step per dividend bit and a decision,
// so a 32-bit prime needs about 2^15 divisors; a next request runs this divisor loop for
// every successor it tests. Reset is asynchronous and active low and empties the output
// register. A result waits there while the next request is worked; only loading a new
// result waits on m_tready.
`default_nettype none

module trial_division_prime_test_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // Bits 31:0 value.
    input  wire logic [tdpt_pkg::DATA_W-1:0]       s_tdata,
    // Bit 0 action (0 test, 1 next prime).
    input  wire logic [tdpt_pkg::USER_IN_W-1:0]    s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // Bits 31:0 prime_value.
    output logic [tdpt_pkg::DATA_W-1:0]            m_tdata,
    // Bit 0 is_prime, bit 1 overflow.
    output logic [tdpt_pkg::USER_OUT_W-1:0]        m_tuser
);
    import tdpt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller sequences candidates, the datapath holds every number.
    tdpt_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tdpt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for trial_division_prime_test_unit: primality tests and next-prime searches.
// A queue-fed stream driver, a scoreboard monitor and a bit-true predictor of the unit.
// Depends on tdpt_pkg and trial_division_prime_test_unit.
`timescale 1ns / 100ps

module testbench;

    // One request as it travels on the input stream, and one result as it leaves.
    typedef struct packed {
        logic                          action;
        logic [tdpt_pkg::DATA_W-1:0]   value;
    } prime_request_t;

    typedef struct packed {
        logic                          is_prime;
        logic [tdpt_pkg::DATA_W-1:0]   prime_value;
        logic                          overflow;
    } prime_result_t;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_TOGGLE,
        READY_MOSTLY
    } ready_mode_e;

    // Largest value that fits in WIDTH bits; written so that a WIDTH of 64 does not wrap.
    localparam longint unsigned VAL_MASK = ((64'd1 << (tdpt_pkg::WIDTH - 1)) << 1) - 64'd1;
    localparam longint unsigned SQ_SAT = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int LONG_HOLD_CYCLES = 6000;
    localparam int LONG_HOLD_AFTER = 40;
    localparam int TAIL_CYCLES = 64;

    logic                               clk;
    logic                               rst_n = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    // Bits 31:0 value.
    logic [tdpt_pkg::DATA_W-1:0]        s_tdata = '0;
    // Bit 0 action.
    logic [tdpt_pkg::USER_IN_W-1:0]     s_tuser = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    // Bits 31:0 prime_value.
    logic [tdpt_pkg::DATA_W-1:0]        m_tdata;
    // Bit 0 is_prime, bit 1 overflow.
    logic [tdpt_pkg::USER_OUT_W-1:0]    m_tuser;

    prime_request_t pending_requests[$];
    prime_result_t  expected_results[$];
    int             mismatch_count = 0;

    // Sender bookkeeping.
    int             burst_left = 0;
    int             gap_left = 0;
    prime_request_t next_req;
    prime_request_t accepted_req;

    // Receiver bookkeeping.
    int             hold_left = 0;
    int             phase_left = 0;
    int             results_seen = 0;
    bit             long_hold_done = 1'b0;
    ready_mode_e    ready_mode = READY_ALWAYS;
    prime_result_t  want;

    trial_division_prime_test_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Odd divisors from 3 upward while the running square stays below n. The square
    // follows the divisor by adding 4(p-1) and saturates instead of wrapping.
    function automatic logic passes_trial_division(longint unsigned n);
        longint unsigned divisor;
        longint unsigned square;
        longint unsigned step;
        if (n < 64'd2)
            return 1'b0;
        if (n == 64'd2 || n == 64'd3)
            return 1'b1;
        if (n[0] == 1'b0)
            return 1'b0;
        divisor = 64'd3;
        square = 64'd9;
        while (square < n && (n % divisor) != 64'd0)
        begin
            divisor += 64'd2;
            step = 64'd4 * (divisor - 64'd1);
            if (square > SQ_SAT - step)
                square = SQ_SAT;
            else
                square += step;
        end
        return (n % divisor) != 64'd0;
    endfunction

    // Result of one request: a verdict with an echo of the value, or the next prime up,
    // or the overflow flag when no prime above the value fits in WIDTH bits.
    function automatic prime_result_t predict_outcome(prime_request_t req);
        longint unsigned v;
        longint unsigned cand;
        logic            found;
        prime_result_t   r;
        v = 64'(req.value) & VAL_MASK;
        if (req.action == tdpt_pkg::ACT_TEST)
        begin
            r.is_prime = passes_trial_division(v);
            r.prime_value = v[tdpt_pkg::DATA_W-1:0];
            r.overflow = 1'b0;
            return r;
        end
        cand = v;
        found = 1'b0;
        while (!found && cand < VAL_MASK)
        begin
            cand++;
            found = passes_trial_division(cand);
        end
        r.is_prime = found;
        r.prime_value = found ? cand[tdpt_pkg::DATA_W-1:0] : '0;
        r.overflow = !found;
        return r;
    endfunction

    task automatic queue_request(logic action, logic [tdpt_pkg::DATA_W-1:0] value);
        pending_requests.push_back(prime_request_t'{action: action, value: value});
    endtask

    // Sender: offers queued requests in bursts separated by idle gaps. Once a request
    // is on the bus it stays there until the unit takes it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                accepted_req.action = s_tuser[0];
                accepted_req.value = s_tdata;
                expected_results.push_back(predict_outcome(accepted_req));
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    next_req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_req.value;
                    s_tuser <= next_req.action;
                    if (burst_left > 1)
                        burst_left--;
                    else if ($urandom_range(0, 5) == 0)
                    begin
                        // A long stretch with no idling on the input side.
                        burst_left = $urandom_range(30, 60);
                        gap_left = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 8);
                        gap_left = $urandom_range(1, 12);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result against the oldest prediction and drives m_tready
    // from a pattern that changes from phase to phase. Once, after enough results,
    // it holds off for a long stretch so that the unit backs up into its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left = 0;
            phase_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with no request waiting: expected none, actual %h/%b",
                             $time, m_tdata, m_tuser);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser[0] !== want.is_prime)
                    begin
                        $display("%0t: is_prime expected %b actual %b (prime_value %h)",
                                 $time, want.is_prime, m_tuser[0], want.prime_value);
                        mismatch_count++;
                    end
                    if (m_tdata !== want.prime_value)
                    begin
                        $display("%0t: prime_value expected %h actual %h",
                                 $time, want.prime_value, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tuser[1] !== want.overflow)
                    begin
                        $display("%0t: overflow expected %b actual %b (prime_value %h)",
                                 $time, want.overflow, m_tuser[1], want.prime_value);
                        mismatch_count++;
                    end
                end
            end
            if (!long_hold_done && results_seen >= LONG_HOLD_AFTER)
            begin
                hold_left = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    ready_mode = ready_mode_e'($urandom_range(0, 3));
                    phase_left = $urandom_range(5, 200);
                end
                phase_left--;
                case (ready_mode)
                    READY_ALWAYS: m_tready <= 1'b1;
                    READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    READY_TOGGLE: m_tready <= ~m_tready;
                    default:      m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Stimulus and end of run. Queue state is looked at on the falling edge, where the
    // clocked processes have settled.
    initial
    begin
        int roll;
        logic act;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: the small cases decided without a divisor, squares of primes, the
        // largest and smallest values, and next-prime searches that run off the top.
        queue_request(tdpt_pkg::ACT_TEST, 32'd0);
        queue_request(tdpt_pkg::ACT_TEST, 32'd1);
        queue_request(tdpt_pkg::ACT_TEST, 32'd2);
        queue_request(tdpt_pkg::ACT_TEST, 32'd3);
        queue_request(tdpt_pkg::ACT_TEST, 32'd4);
        queue_request(tdpt_pkg::ACT_TEST, 32'd5);
        queue_request(tdpt_pkg::ACT_TEST, 32'd9);
        queue_request(tdpt_pkg::ACT_TEST, 32'd15);
        queue_request(tdpt_pkg::ACT_TEST, 32'd25);
        queue_request(tdpt_pkg::ACT_TEST, 32'd121);
        queue_request(tdpt_pkg::ACT_TEST, 32'd97);
        queue_request(tdpt_pkg::ACT_TEST, 32'd65521);
        queue_request(tdpt_pkg::ACT_TEST, 32'd16777213);
        queue_request(tdpt_pkg::ACT_TEST, 32'hFFFF_FFFF);
        queue_request(tdpt_pkg::ACT_TEST, 32'hFFFF_FFFE);
        queue_request(tdpt_pkg::ACT_TEST, 32'h8000_0000);
        queue_request(tdpt_pkg::ACT_NEXT, 32'd0);
        queue_request(tdpt_pkg::ACT_NEXT, 32'd1);
        queue_request(tdpt_pkg::ACT_NEXT, 32'd2);
        queue_request(tdpt_pkg::ACT_NEXT, 32'd3);
        queue_request(tdpt_pkg::ACT_NEXT, 32'd13);
        queue_request(tdpt_pkg::ACT_NEXT, 32'd65520);
        queue_request(tdpt_pkg::ACT_NEXT, 32'hFFFF_FFFE);
        queue_request(tdpt_pkg::ACT_NEXT, 32'hFFFF_FFFF);

        // The stimulus pauses here until every directed result is back.
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);

        // Random: mostly small values, which keep the divisor loop short. Large values
        // are made even or a multiple of three so every bit toggles at low cost, and
        // large next-prime searches stay near the top where they overflow at once.
        repeat (76)
        begin
            roll = $urandom_range(0, 99);
            act = 1'($urandom_range(0, 1));
            if (roll < 55)
                queue_request(act, $urandom_range(0, 4095));
            else if (roll < 67)
                queue_request(tdpt_pkg::ACT_TEST, $urandom() & 32'hFFFF_FFFE);
            else if (roll < 79)
                queue_request(tdpt_pkg::ACT_TEST, $urandom_range(0, 32'h5555_5555) * 3);
            else if (roll < 85)
                queue_request(tdpt_pkg::ACT_TEST, $urandom_range(4096, 32'h0010_0000));
            else if (roll < 93)
                queue_request(tdpt_pkg::ACT_NEXT, $urandom_range(4096, 65535));
            else
                queue_request(tdpt_pkg::ACT_NEXT, 32'hFFFF_FFFF - $urandom_range(0, 2));
        end

        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog, several times the slowest expected run.
    initial
    begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
